// ----- src/psd_pkg.sv -----
// Package for the pitch salience decoder: sizes, row snapshot and config types,
// back-end states and the constant root table of the exp2 unit. No dependencies.
`default_nettype none
package psd_pkg;

    localparam int NUM_BINS    = 360;
    localparam int HALF_WINDOW = 4;
    localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;

    localparam int SAL_W   = 16;
    localparam int PIDX_W  = $clog2(NUM_BINS);
    localparam int CNT_W   = $clog2(NUM_BINS + 1);
    localparam int FILL_W  = $clog2(HALF_WINDOW + 1);
    localparam int POS_W   = $clog2(NUM_BINS + HALF_WINDOW);
    localparam int WK_W    = $clog2(WIN_LEN);
    localparam int WSUM_W  = SAL_W + $clog2(WIN_LEN + 1);
    localparam int NUM_W   = SAL_W + POS_W + $clog2(WIN_LEN + 1);
    localparam int STEP_W  = 10;
    localparam int PROD_W  = STEP_W + NUM_W;
    localparam int DIVD_W  = PROD_W + 1;
    localparam int DCNT_W  = $clog2(DIVD_W + 1);
    localparam int CENT_W  = DIVD_W + 1;

    // One octave is 1200 cents, kept in 1/16 cent.
    localparam int OCTAVE      = 19200;
    localparam int OCT_SAT     = 9;
    localparam int CR_W        = 18;
    localparam int FRAC_BITS   = 20;
    localparam int FCNT_W      = 5;
    localparam int PITCH_SCALE = 160;
    localparam int PITCH_MAX   = 65535;

    // Octave fraction r * 2^20 / 19200 equals r * 4096 / 75; taken exactly as
    // r * ceil(2^34 / 75) >> 22 for any remainder below one octave.
    localparam int FRAC_RECIP  = 229064923;
    localparam int FRAC_SHIFT  = 22;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [1:0] REG_CENTS_BASE = 2'd1;
    localparam logic [1:0] REG_CENTS_STEP = 2'd2;

    localparam logic [15:0] RST_THRESHOLD  = 16'd1966;
    localparam logic [15:0] RST_CENTS_BASE = 16'd31958;
    localparam logic [9:0]  RST_CENTS_STEP = 10'd320;

    typedef struct packed {
        logic [SAL_W-1:0]                 peak_value;
        logic [PIDX_W-1:0]                peak_index;
        logic [WIN_LEN-1:0][SAL_W-1:0]    window;
    } psd_row_t;

    typedef struct packed {
        logic [15:0]       threshold;
        logic [15:0]       cents_base;
        logic [STEP_W-1:0] cents_step;
    } psd_cfg_t;

    typedef enum logic [3:0] {
        B_IDLE, B_ACC, B_MUL, B_DIV, B_CENTS, B_OCT, B_FRAC,
        B_EXPM, B_EXPR, B_SCALE, B_FINAL, B_OUT
    } psd_back_state_t;

    // Floor square root of a 64-bit value, digit by digit.
    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        x    = x_in;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (bitv != 64'd0 && x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Repeated root of 2.0 in Q30: 2^(2^-k).
    function automatic logic [31:0] root_of(input int k);
        logic [63:0] t;
        t = 64'd2 << 30;
        for (int i = 0; i < k; i++)
        begin
            t = isqrt64(t << 30);
        end
        return t[31:0];
    endfunction

    localparam logic [31:0] ROOT_TAB [0:FRAC_BITS] = '{
        root_of(0),  root_of(1),  root_of(2),  root_of(3),  root_of(4),
        root_of(5),  root_of(6),  root_of(7),  root_of(8),  root_of(9),
        root_of(10), root_of(11), root_of(12), root_of(13), root_of(14),
        root_of(15), root_of(16), root_of(17), root_of(18), root_of(19),
        root_of(20)
    };

endpackage
`default_nettype wire

// ----- src/pitch_salience_decode_unit.sv -----
// Pitch salience decoder top level. Bins are taken one per cycle while the
// two-entry row queue has room; each row end is decoded by the back end (9
// window sums, 40-step divide, octave split, one fraction step, up to 20 root
// products); rows that arrive faster stall the input once the queue is full.
// Reset (async, active low) clears row state, the queue and output valid; the
// registers return to 1966, 31958 and 320.
`default_nettype none
module pitch_salience_decode_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] salience
    input  wire logic        s_tlast,   // last_bin
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] pitch_hz
    output logic             m_tuser,   // [0] voiced
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import psd_pkg::*;

    psd_cfg_t  cfg_reg;
    logic      push;
    logic      full;
    logic      pop;
    logic      not_empty;
    psd_row_t  push_row;
    psd_row_t  pop_row;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold  <= RST_THRESHOLD;
            cfg_reg.cents_base <= RST_CENTS_BASE;
            cfg_reg.cents_step <= RST_CENTS_STEP;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_THRESHOLD:  cfg_reg.threshold  <= cfg_data;
                REG_CENTS_BASE: cfg_reg.cents_base <= cfg_data;
                REG_CENTS_STEP: cfg_reg.cents_step <= cfg_data[STEP_W-1:0];
                default:        ;
            endcase
        end
    end

    psd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_salience (s_tdata),
        .in_last     (s_tlast),
        .push        (push),
        .push_row    (push_row),
        .queue_full  (full)
    );

    psd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_row  (push_row),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_row   (pop_row)
    );

    psd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .row_valid  (not_empty),
        .row_in     (pop_row),
        .row_pop    (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pitch  (m_tdata),
        .out_voiced (m_tuser)
    );

endmodule
`default_nettype wire

// ----- src/psd_front.sv -----
// Front end of the pitch salience decoder: peak tracking and window capture.
// Depends on psd_pkg; hands one row snapshot per row end to the queue.
`default_nettype none
module psd_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [15:0]              in_salience,
    input  wire logic                     in_last,
    output logic                          push,
    output psd_pkg::psd_row_t             push_row,
    input  wire logic                     queue_full
);
    import psd_pkg::*;

    logic [SAL_W-1:0]               peak_value_reg, peak_value_next;
    logic [PIDX_W-1:0]              peak_index_reg, peak_index_next;
    logic [CNT_W-1:0]               bin_counter_reg, bin_counter_next;
    logic [FILL_W-1:0]              fill_reg, fill_next;
    logic [HALF_WINDOW-1:0][SAL_W-1:0] recent_reg, recent_next;
    logic [WIN_LEN-1:0][SAL_W-1:0]  window_reg, window_next;
    logic [PIDX_W-1:0]              idx;
    logic                           in_row;
    logic                           accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign in_row   = bin_counter_reg < CNT_W'(NUM_BINS);
    assign idx      = in_row ? bin_counter_reg[PIDX_W-1:0] : PIDX_W'(NUM_BINS - 1);

    // Next row state for the beat on the input.
    always_comb
    begin
        peak_value_next = peak_value_reg;
        peak_index_next = peak_index_reg;
        fill_next       = fill_reg;
        window_next     = window_reg;
        if (in_salience > peak_value_reg)
        begin
            peak_value_next = in_salience;
            peak_index_next = idx;
            for (int k = 0; k < WIN_LEN; k++)
            begin
                if (k < HALF_WINDOW)
                    window_next[k] = recent_reg[k];
                else if (k == HALF_WINDOW)
                    window_next[k] = in_salience;
                else
                    window_next[k] = '0;
            end
            fill_next = '0;
        end
        else if (fill_reg < FILL_W'(HALF_WINDOW) && in_row)
        begin
            for (int k = HALF_WINDOW + 1; k < WIN_LEN; k++)
            begin
                if (int'(fill_reg) == k - HALF_WINDOW - 1)
                    window_next[k] = in_salience;
            end
            fill_next = fill_reg + 1'b1;
        end
        for (int k = 0; k + 1 < HALF_WINDOW; k++)
            recent_next[k] = recent_reg[k + 1];
        recent_next[HALF_WINDOW-1] = in_salience;
        bin_counter_next = in_row ? bin_counter_reg + 1'b1 : bin_counter_reg;
    end

    assign push                = accept && in_last;
    assign push_row.peak_value = peak_value_next;
    assign push_row.peak_index = peak_index_next;
    assign push_row.window     = window_next;

    // Row state; cleared after the last bin of a row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_value_reg  <= '0;
            peak_index_reg  <= '0;
            bin_counter_reg <= '0;
            fill_reg        <= '0;
            recent_reg      <= '0;
            window_reg      <= '0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                peak_value_reg  <= '0;
                peak_index_reg  <= '0;
                bin_counter_reg <= '0;
                fill_reg        <= '0;
                recent_reg      <= '0;
                window_reg      <= '0;
            end
            else
            begin
                peak_value_reg  <= peak_value_next;
                peak_index_reg  <= peak_index_next;
                bin_counter_reg <= bin_counter_next;
                fill_reg        <= fill_next;
                recent_reg      <= recent_next;
                window_reg      <= window_next;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/psd_queue.sv -----
// Two-entry queue of row snapshots between front and back end.
// Depends on psd_pkg for the snapshot type.
`default_nettype none
module psd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  psd_pkg::psd_row_t  push_row,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output psd_pkg::psd_row_t  pop_row
);
    import psd_pkg::*;

    psd_row_t    entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign pop_row   = entry_reg[rd_ptr_reg];

    // Storage is written only at the write pointer.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_row;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

// ----- src/psd_back.sv -----
// Back end of the pitch salience decoder: weighted mean, divider, octave split,
// exp2 by root products and the output register. Depends on psd_pkg.
`default_nettype none
module psd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  psd_pkg::psd_cfg_t  cfg,
    input  wire logic          row_valid,
    input  psd_pkg::psd_row_t  row_in,
    output logic               row_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [15:0]        out_pitch,
    output logic               out_voiced
);
    import psd_pkg::*;

    psd_back_state_t     state_reg, state_next;
    psd_row_t            row_reg, row_next;
    logic [WK_W-1:0]     k_reg, k_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [WSUM_W-1:0]   wsum_reg, wsum_next;
    logic [63:0]         prod_reg, prod_next;
    logic [DIVD_W-1:0]   dvd_reg, dvd_next;
    logic [WSUM_W-1:0]   rem_reg, rem_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic [CR_W-1:0]     cr_reg, cr_next;
    logic [3:0]          oct_reg, oct_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [FCNT_W-1:0]   fk_reg, fk_next;
    logic [31:0]         mant_reg, mant_next;
    logic [15:0]         res_pitch_reg, res_pitch_next;
    logic                res_voiced_reg, res_voiced_next;
    logic                out_valid_reg, out_valid_next;
    logic [15:0]         out_pitch_reg, out_pitch_next;
    logic                out_voiced_reg, out_voiced_next;

    logic [WSUM_W:0]     rem_sh;
    logic [CENT_W-1:0]   cents;
    logic [63:0]         scaled;
    int                  pos_i;

    assign out_valid  = out_valid_reg;
    assign out_pitch  = out_pitch_reg;
    assign out_voiced = out_voiced_reg;

    // Sequencer for one row.
    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        k_next          = k_reg;
        num_next        = num_reg;
        wsum_next       = wsum_reg;
        prod_next       = prod_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        dcnt_next       = dcnt_reg;
        cr_next         = cr_reg;
        oct_next        = oct_reg;
        frac_next       = frac_reg;
        fk_next         = fk_reg;
        mant_next       = mant_reg;
        res_pitch_next  = res_pitch_reg;
        res_voiced_next = res_voiced_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_pitch_next  = out_pitch_reg;
        out_voiced_next = out_voiced_reg;
        row_pop         = 1'b0;
        rem_sh          = {rem_reg, dvd_reg[DIVD_W-1]};
        cents           = CENT_W'(cfg.cents_base) + CENT_W'(dvd_reg);
        scaled          = (prod_reg << oct_reg) + (64'd1 << 29);
        pos_i           = int'(row_reg.peak_index) + int'(k_reg) - HALF_WINDOW;

        case (state_reg)
            B_IDLE:
            begin
                if (row_valid)
                begin
                    row_pop    = 1'b1;
                    row_next   = row_in;
                    k_next     = '0;
                    num_next   = '0;
                    wsum_next  = '0;
                    state_next = B_ACC;
                end
            end
            // One window bin per cycle into the weighted and plain sums.
            B_ACC:
            begin
                if (pos_i >= 0)
                begin
                    num_next = num_reg + NUM_W'(row_reg.window[k_reg] * POS_W'(pos_i));
                    wsum_next = wsum_reg + WSUM_W'(row_reg.window[k_reg]);
                end
                k_next = k_reg + 1'b1;
                if (k_reg == WK_W'(WIN_LEN - 1))
                    state_next = B_MUL;
            end
            B_MUL:
            begin
                if (row_reg.peak_value > cfg.threshold && wsum_reg != '0)
                begin
                    prod_next  = 64'(cfg.cents_step * num_reg);
                    state_next = B_DIV;
                    dvd_next   = DIVD_W'(64'(cfg.cents_step * num_reg))
                                 + DIVD_W'(wsum_reg >> 1);
                    rem_next   = '0;
                    dcnt_next  = '0;
                end
                else
                begin
                    res_pitch_next  = '0;
                    res_voiced_next = 1'b0;
                    state_next      = B_OUT;
                end
            end
            // Restoring division, one quotient bit per cycle.
            B_DIV:
            begin
                if (rem_sh >= {1'b0, wsum_reg})
                begin
                    rem_next = WSUM_W'(rem_sh - {1'b0, wsum_reg});
                    dvd_next = {dvd_reg[DIVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[WSUM_W-1:0];
                    dvd_next = {dvd_reg[DIVD_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(DIVD_W - 1))
                    state_next = B_CENTS;
            end
            B_CENTS:
            begin
                if (cents == '0)
                begin
                    res_pitch_next  = '0;
                    res_voiced_next = 1'b0;
                    state_next      = B_OUT;
                end
                else if (cents >= CENT_W'(OCT_SAT * OCTAVE))
                begin
                    res_pitch_next  = 16'(PITCH_MAX);
                    res_voiced_next = 1'b1;
                    state_next      = B_OUT;
                end
                else
                begin
                    cr_next    = cents[CR_W-1:0];
                    oct_next   = '0;
                    state_next = B_OCT;
                end
            end
            // Octave count by repeated subtraction.
            B_OCT:
            begin
                if (cr_reg >= CR_W'(OCTAVE))
                begin
                    cr_next  = cr_reg - CR_W'(OCTAVE);
                    oct_next = oct_reg + 1'b1;
                end
                else
                begin
                    frac_next  = '0;
                    fk_next    = '0;
                    state_next = B_FRAC;
                end
            end
            // Fraction of an octave by reciprocal multiplication.
            B_FRAC:
            begin
                frac_next  = FRAC_BITS'((64'(cr_reg) * 64'(FRAC_RECIP)) >> FRAC_SHIFT);
                fk_next    = FCNT_W'(1);
                mant_next  = 32'd1 << 30;
                state_next = B_EXPM;
            end
            // Multiply in the root of each set fraction bit, MSB first.
            B_EXPM:
            begin
                if (frac_reg[FRAC_BITS-1])
                begin
                    prod_next  = 64'(mant_reg) * 64'(ROOT_TAB[fk_reg]);
                    state_next = B_EXPR;
                end
                else
                begin
                    frac_next = frac_reg << 1;
                    fk_next   = fk_reg + 1'b1;
                    if (fk_reg == FCNT_W'(FRAC_BITS))
                        state_next = B_SCALE;
                end
            end
            B_EXPR:
            begin
                mant_next  = 32'((prod_reg + (64'd1 << 29)) >> 30);
                frac_next  = frac_reg << 1;
                fk_next    = fk_reg + 1'b1;
                state_next = (fk_reg == FCNT_W'(FRAC_BITS)) ? B_SCALE : B_EXPM;
            end
            B_SCALE:
            begin
                prod_next  = 64'(mant_reg) * 64'(PITCH_SCALE);
                state_next = B_FINAL;
            end
            B_FINAL:
            begin
                if ((scaled >> 30) > 64'(PITCH_MAX))
                    res_pitch_next = 16'(PITCH_MAX);
                else
                    res_pitch_next = scaled[45:30];
                res_voiced_next = 1'b1;
                state_next      = B_OUT;
            end
            // Hand the result to the output register once it is free.
            B_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_pitch_next  = res_pitch_reg;
                    out_voiced_next = res_voiced_reg;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        k_reg          <= k_next;
        num_reg        <= num_next;
        wsum_reg       <= wsum_next;
        prod_reg       <= prod_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        dcnt_reg       <= dcnt_next;
        cr_reg         <= cr_next;
        oct_reg        <= oct_next;
        frac_reg       <= frac_next;
        fk_reg         <= fk_next;
        mant_reg       <= mant_next;
        res_pitch_reg  <= res_pitch_next;
        res_voiced_reg <= res_voiced_next;
        out_pitch_reg  <= out_pitch_next;
        out_voiced_reg <= out_voiced_next;
    end

endmodule
`default_nettype wire
